@@ sv/uftx_pkg.sv @@
package uftx_pkg;

	localparam int unsigned QUEUE_DEPTH_DEF = 64;
	localparam int unsigned DATA_W          = 8;
	localparam int unsigned BIT_IDX_W       = 4;

	typedef enum logic {
		KIND_PUSH = 1'b0,
		KIND_TICK = 1'b1
	} kind_t;

	typedef struct packed {
		kind_t             kind;
		logic [DATA_W-1:0] data;
	} item_t;

endpackage

@@ sv/uftx_in_queue.sv @@
module uftx_in_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            s_tvalid,
	output logic            s_tready,
	input  logic [7:0]      s_tdata,
	input  logic [0:0]      s_tuser,
	output logic            q_valid,
	output uftx_pkg::item_t q_item,
	input  logic            q_pop
);
	import uftx_pkg::*;

	item_t      slot_q [2];
	logic       wr_idx_q;
	logic       rd_idx_q;
	logic [1:0] level_q;
	logic       push;
	item_t      item_in;

	always_comb begin
		item_in.kind = (s_tuser[0] == 1'b1) ? KIND_TICK : KIND_PUSH;
		item_in.data = s_tdata[DATA_W-1:0];
	end

	assign s_tready = (level_q != 2'd2);
	assign push     = s_tvalid && s_tready;
	assign q_valid  = (level_q != 2'd0);
	assign q_item   = slot_q[rd_idx_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_idx_q] <= item_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_idx_q <= 1'b0;
			rd_idx_q <= 1'b0;
			level_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_idx_q <= ~wr_idx_q;
			end
			if (q_pop) begin
				rd_idx_q <= ~rd_idx_q;
			end
			unique case ({push, q_pop})
				2'b10:   level_q <= level_q + 2'd1;
				2'b01:   level_q <= level_q - 2'd1;
				default: level_q <= level_q;
			endcase
		end
	end

endmodule

@@ sv/uftx_engine.sv @@
module uftx_engine #(
	parameter int unsigned QUEUE_DEPTH = uftx_pkg::QUEUE_DEPTH_DEF,
	parameter int unsigned CNT_W       = $clog2(QUEUE_DEPTH + 1),
	parameter int unsigned OUT_W       = ((3 + CNT_W + 7) / 8) * 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             q_valid,
	input  uftx_pkg::item_t  q_item,
	output logic             q_pop,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [0:0]       cfg_data,
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [OUT_W-1:0] m_tdata
);
	import uftx_pkg::*;

	localparam int unsigned PTR_W = (QUEUE_DEPTH > 2) ? $clog2(QUEUE_DEPTH) : 1;
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

	logic [DATA_W-1:0]    mem [QUEUE_DEPTH];
	logic [DATA_W-1:0]    head_q;
	logic [PTR_W-1:0]     wr_ptr_q, wr_ptr_d;
	logic [PTR_W-1:0]     rd_ptr_q, rd_ptr_d;
	logic [CNT_W-1:0]     fill_q, fill_d;
	logic                 frame_q, frame_d;
	logic [BIT_IDX_W-1:0] idx_q, idx_d;
	logic                 par_q, par_d;
	logic                 par_done_q, par_done_d;
	logic                 parity_odd_q;
	logic                 advance;
	logic                 mem_we;
	logic                 accepted;
	logic                 line;
	logic                 m_tvalid_q;
	logic [OUT_W-1:0]     m_tdata_q;

	assign cfg_ready = 1'b1;
	assign advance   = !m_tvalid_q || m_tready;
	assign q_pop     = q_valid && advance;
	assign m_tvalid  = m_tvalid_q;
	assign m_tdata   = m_tdata_q;

	always_comb begin
		wr_ptr_d   = wr_ptr_q;
		rd_ptr_d   = rd_ptr_q;
		fill_d     = fill_q;
		frame_d    = frame_q;
		idx_d      = idx_q;
		par_d      = par_q;
		par_done_d = par_done_q;
		mem_we     = 1'b0;
		accepted   = 1'b0;
		line       = 1'b1;
		unique case (q_item.kind)
			KIND_PUSH: begin
				if (fill_q != FULL_CNT) begin
					mem_we   = 1'b1;
					wr_ptr_d = (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + PTR_W'(1);
					fill_d   = fill_q + CNT_W'(1);
					accepted = 1'b1;
				end
			end
			KIND_TICK: begin
				if (frame_q) begin
					if (idx_q < BIT_IDX_W'(DATA_W)) begin
						line  = head_q[idx_q[2:0]];
						idx_d = idx_q + BIT_IDX_W'(1);
						par_d = par_q ^ line;
					end else if (!par_done_q) begin
						line       = par_q;
						par_done_d = 1'b1;
					end else begin
						// Stop bit: the byte leaves the queue only now.
						rd_ptr_d   = (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + PTR_W'(1);
						fill_d     = (fill_q != '0) ? fill_q - CNT_W'(1) : fill_q;
						frame_d    = 1'b0;
						idx_d      = '0;
						par_done_d = 1'b0;
						par_d      = 1'b1;
					end
				end else if (fill_q != '0) begin
					line       = 1'b0;
					frame_d    = 1'b1;
					idx_d      = '0;
					par_done_d = 1'b0;
					par_d      = parity_odd_q;
				end
			end
			default: begin
			end
		endcase
	end

	// The head entry is reread every cycle; a pushed byte is counted, so it is
	// never overwritten while it is being sent.
	always_ff @(posedge clk) begin
		if (q_pop && mem_we) begin
			mem[wr_ptr_q] <= q_item.data;
		end
		head_q <= mem[rd_ptr_q];
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			m_tdata_q <= OUT_W'({fill_d, (fill_d == '0), line, accepted});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q     <= '0;
			rd_ptr_q     <= '0;
			fill_q       <= '0;
			frame_q      <= 1'b0;
			idx_q        <= '0;
			par_q        <= 1'b1;
			par_done_q   <= 1'b0;
			parity_odd_q <= 1'b1;
			m_tvalid_q   <= 1'b0;
		end else begin
			if (cfg_valid) begin
				parity_odd_q <= cfg_data[0];
			end
			if (advance) begin
				m_tvalid_q <= q_valid;
			end
			if (q_pop) begin
				wr_ptr_q   <= wr_ptr_d;
				rd_ptr_q   <= rd_ptr_d;
				fill_q     <= fill_d;
				frame_q    <= frame_d;
				idx_q      <= idx_d;
				par_q      <= par_d;
				par_done_q <= par_done_d;
			end
		end
	end

endmodule

@@ sv/uart_frame_transmitter_with_fifo_core.sv @@
// Channel   Direction  Payload
// s_*       in         tdata: data_byte[7:0]; tuser: command[0] (0 push, 1 bit tick)
// m_*       out        tdata: write_accepted, line_bit, transfer_done, queued_count
// cfg_*     in         cfg_data: parity_odd (1 odd, 0 even); always ready
//
// One item per cycle is sustained while the output is not stalled; each item is registered
// first in the two-entry input queue and then in the engine's output register.
// Reset is asynchronous and leaves the line idle, the FIFO empty and odd parity.
// A stalled output holds the engine; the input queue absorbs up to two items.
// The head byte is read from the byte store every cycle through a registered port.
module uart_frame_transmitter_with_fifo_core #(
	parameter int unsigned QUEUE_DEPTH = uftx_pkg::QUEUE_DEPTH_DEF,
	parameter int unsigned CNT_W       = $clog2(QUEUE_DEPTH + 1),
	parameter int unsigned OUT_W       = ((3 + CNT_W + 7) / 8) * 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [7:0]       s_tdata,   // [7:0] data_byte
	input  logic [0:0]       s_tuser,   // [0] command
	output logic             m_tvalid,
	input  logic             m_tready,
	// [0] write_accepted, [1] line_bit, [2] transfer_done, [3 +: CNT_W] queued_count
	output logic [OUT_W-1:0] m_tdata,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [0:0]       cfg_data
);
	import uftx_pkg::*;

	logic  q_valid;
	item_t q_item;
	logic  q_pop;

	uftx_in_queue u_in_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.q_valid  (q_valid),
		.q_item   (q_item),
		.q_pop    (q_pop)
	);

	uftx_engine #(
		.QUEUE_DEPTH (QUEUE_DEPTH),
		.CNT_W       (CNT_W),
		.OUT_W       (OUT_W)
	) u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_item    (q_item),
		.q_pop     (q_pop),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

endmodule
